// ===== rtl/ptp_pkg.sv =====
// Shared types, constants and constant functions of the polar to plot point block.
package ptp_pkg;

   localparam int PLOT_RADIUS_DEF    = 96;
   localparam int TRIG_FRAC_BITS_DEF = 15;
   localparam int QUEUE_DEPTH        = 4;

   localparam int DIST_W     = 15;
   localparam int BEAR_W     = 9;
   localparam int PIX_W      = 12;
   localparam int RANGE_W    = 16;
   localparam int CENTER_W   = 10;
   localparam int FULL_W     = 20;
   localparam int IDX_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int TAB_N      = 91;

   localparam logic [RANGE_W-1:0]  RANGE_RESET    = 16'd30;
   localparam logic [CENTER_W-1:0] CENTER_RESET   = 10'd128;
   localparam logic [BEAR_W-1:0]   ANGLE_QUARTER  = 9'd90;
   localparam logic [BEAR_W-1:0]   ANGLE_HALF     = 9'd180;
   localparam logic [BEAR_W-1:0]   ANGLE_3QUARTER = 9'd270;
   localparam logic [BEAR_W-1:0]   ANGLE_FULL     = 9'd360;

   localparam longint unsigned DEG_Q30 = 64'd18740330;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint unsigned TAYLOR_DIV [12] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE    = 2'd0,
      CSR_CENTER_X = 2'd1,
      CSR_CENTER_Y = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             neg;
      logic [IDX_W-1:0] idx;
   } trig_ref_type;

   typedef struct packed {
      logic [FULL_W-1:0]   full;
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
   } cfg_type;

   function automatic int num_width(input int radius);
      return DIST_W + $clog2(radius + 1) + 8;
   endfunction

   function automatic longint unsigned sin_q30(input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      x    = longint'(k) * DEG_Q30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 12; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (k == 90) begin
         sum = ONE_Q30;
      end
      return sum;
   endfunction

   function automatic longint unsigned trig_entry(input int unsigned k,
                                                  input int unsigned frac);
      return (sin_q30(k) + (64'd1 << (29 - frac))) >> (30 - frac);
   endfunction

   function automatic trig_ref_type fold_angle(input logic [BEAR_W-1:0] a);
      trig_ref_type r;
      logic [BEAR_W-1:0] v;
      if (a <= ANGLE_QUARTER) begin
         v     = a;
         r.neg = 1'b0;
      end else if (a <= ANGLE_HALF) begin
         v     = ANGLE_HALF - a;
         r.neg = 1'b0;
      end else if (a <= ANGLE_3QUARTER) begin
         v     = a - ANGLE_HALF;
         r.neg = 1'b1;
      end else begin
         v     = ANGLE_FULL - a;
         r.neg = 1'b1;
      end
      r.idx = v[IDX_W-1:0];
      return r;
   endfunction

endpackage

// ===== rtl/ptp_front.sv =====
// Front end: configuration registers, input acceptance and classification into queue words.
module ptp_front #(
   parameter int PLOT_RADIUS = ptp_pkg::PLOT_RADIUS_DEF,
   parameter int NUM_W       = ptp_pkg::num_width(PLOT_RADIUS),
   parameter int WORD_W      = NUM_W + 2 * $bits(ptp_pkg::trig_ref_type)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ptp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ptp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ptp_pkg::REQ_DATA_W-1:0]    req_tdata,  // distance_tenths[14:0], bearing[23:15]
   input  logic                              q_full,
   output logic                              q_push,
   output logic [WORD_W-1:0]                 q_data,
   output ptp_pkg::cfg_type                  cfg
);

   logic [ptp_pkg::RANGE_W-1:0]  range_ff,    range_in;
   logic [ptp_pkg::CENTER_W-1:0] center_x_ff, center_x_in;
   logic [ptp_pkg::CENTER_W-1:0] center_y_ff, center_y_in;

   logic [ptp_pkg::RANGE_W-1:0]  rng;
   logic [ptp_pkg::FULL_W-1:0]   full;
   logic [ptp_pkg::DIST_W-1:0]   distance;
   logic [ptp_pkg::DIST_W-1:0]   dc;
   logic [ptp_pkg::BEAR_W-1:0]   bear_raw;
   logic [ptp_pkg::BEAR_W-1:0]   bear;
   logic [ptp_pkg::BEAR_W:0]     cos_sum;
   logic [ptp_pkg::BEAR_W-1:0]   cos_bear;
   logic [NUM_W-1:0]             num;
   ptp_pkg::trig_ref_type        sin_ref;
   ptp_pkg::trig_ref_type        cos_ref;

   always_comb begin
      range_in    = range_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_we) begin
         case (ptp_pkg::csr_index_type'(csr_index))
            ptp_pkg::CSR_RANGE: begin
               range_in = csr_wdata;
            end
            ptp_pkg::CSR_CENTER_X: begin
               center_x_in = csr_wdata[ptp_pkg::CENTER_W-1:0];
            end
            ptp_pkg::CSR_CENTER_Y: begin
               center_y_in = csr_wdata[ptp_pkg::CENTER_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff    <= ptp_pkg::RANGE_RESET;
         center_x_ff <= ptp_pkg::CENTER_RESET;
         center_y_ff <= ptp_pkg::CENTER_RESET;
      end else begin
         range_ff    <= range_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

   always_comb begin
      rng  = (range_ff == '0) ? ptp_pkg::RANGE_RESET : range_ff;
      full = (ptp_pkg::FULL_W'(rng) << 3) + (ptp_pkg::FULL_W'(rng) << 1);

      distance = req_tdata[ptp_pkg::DIST_W-1:0];
      bear_raw = req_tdata[ptp_pkg::DIST_W +: ptp_pkg::BEAR_W];

      dc  = (ptp_pkg::FULL_W'(distance) < full) ? distance : full[ptp_pkg::DIST_W-1:0];
      num = (NUM_W'(dc) * NUM_W'(PLOT_RADIUS)) << 8;

      bear     = (bear_raw >= ptp_pkg::ANGLE_FULL) ? bear_raw - ptp_pkg::ANGLE_FULL : bear_raw;
      cos_sum  = {1'b0, bear} + {1'b0, ptp_pkg::ANGLE_QUARTER};
      cos_bear = (cos_sum >= {1'b0, ptp_pkg::ANGLE_FULL}) ?
                 ptp_pkg::BEAR_W'(cos_sum - {1'b0, ptp_pkg::ANGLE_FULL}) :
                 cos_sum[ptp_pkg::BEAR_W-1:0];

      sin_ref = ptp_pkg::fold_angle(bear);
      cos_ref = ptp_pkg::fold_angle(cos_bear);
   end

   assign req_tready   = !q_full;
   assign q_push       = req_tvalid && !q_full;
   assign q_data       = {num, sin_ref, cos_ref};
   assign cfg.full     = full;
   assign cfg.center_x = center_x_ff;
   assign cfg.center_y = center_y_ff;

endmodule

// ===== rtl/ptp_queue.sv =====
// Short register queue between the front end and the back end.
module ptp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ptp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff,  count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

endmodule

// ===== rtl/ptp_back.sv =====
// Back end: trig lookup, pipelined radius divider, scaling, rounding and the output register.
module ptp_back #(
   parameter int PLOT_RADIUS    = ptp_pkg::PLOT_RADIUS_DEF,
   parameter int TRIG_FRAC_BITS = ptp_pkg::TRIG_FRAC_BITS_DEF,
   parameter int NUM_W          = ptp_pkg::num_width(PLOT_RADIUS),
   parameter int WORD_W         = NUM_W + 2 * $bits(ptp_pkg::trig_ref_type)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   output logic                           q_pop,
   input  logic [WORD_W-1:0]              q_data,
   input  ptp_pkg::cfg_type               cfg,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ptp_pkg::RSP_DATA_W-1:0] rsp_tdata   // pixel_x[11:0], pixel_y[23:12]
);

   localparam int QMAX = 256 * PLOT_RADIUS;
   localparam int QW   = $clog2(QMAX + 1);
   localparam int TW   = TRIG_FRAC_BITS + 1;
   localparam int MW   = QW + TW;
   localparam int FW   = ptp_pkg::FULL_W;
   localparam int XW   = ptp_pkg::PIX_W;
   localparam int MUL  = QW + 1;
   localparam int OUTS = QW + 2;

   typedef struct packed {
      logic          sneg;
      logic [TW-1:0] smag;
      logic          cneg;
      logic [TW-1:0] cmag;
   } trig_type;

   logic [TW-1:0] sin_tab [ptp_pkg::TAB_N];

   for (genvar k = 0; k < ptp_pkg::TAB_N; k++) begin : g_tab
      assign sin_tab[k] = TW'(ptp_pkg::trig_entry(k, TRIG_FRAC_BITS));
   end

   logic                  en;
   logic                  v_ff   [OUTS+1];
   logic [FW-1:0]         rem_ff [QW+1];
   logic [FW-1:0]         rem_in [QW+1];
   logic [QW-1:0]         quo_ff [QW+1];
   logic [QW-1:0]         quo_in [QW+1];
   logic [QW-1:0]         nlo_ff [QW+1];
   logic [QW-1:0]         nlo_in [QW+1];
   trig_type              trig_ff [QW+1];
   trig_type              trig_in [QW+1];

   logic [NUM_W-1:0]      q_num;
   ptp_pkg::trig_ref_type q_sin;
   ptp_pkg::trig_ref_type q_cos;

   logic [MW-1:0]         mx_ff, mx_in;
   logic [MW-1:0]         my_ff, my_in;
   logic                  nx_ff, ny_ff;

   logic [MW:0]           rx;
   logic [MW:0]           ry;
   logic [XW-1:0]         dx;
   logic [XW-1:0]         dy;
   logic [XW-1:0]         px_ff, px_in;
   logic [XW-1:0]         py_ff, py_in;

   assign en    = !v_ff[OUTS] || rsp_tready;
   assign q_pop = en && q_valid;

   assign {q_num, q_sin, q_cos} = q_data;

   always_comb begin
      rem_in[0]       = FW'(q_num >> QW);
      nlo_in[0]       = q_num[QW-1:0];
      quo_in[0]       = '0;
      trig_in[0].sneg = q_sin.neg;
      trig_in[0].smag = sin_tab[q_sin.idx];
      trig_in[0].cneg = q_cos.neg;
      trig_in[0].cmag = sin_tab[q_cos.idx];
   end

   for (genvar s = 1; s <= QW; s++) begin : g_div
      logic [FW:0] t;
      logic        ge;
      always_comb begin
         t          = {rem_ff[s-1], nlo_ff[s-1][QW-1]};
         ge         = (t >= {1'b0, cfg.full});
         rem_in[s]  = ge ? FW'(t - {1'b0, cfg.full}) : t[FW-1:0];
         quo_in[s]  = {quo_ff[s-1][QW-2:0], ge};
         nlo_in[s]  = nlo_ff[s-1] << 1;
         trig_in[s] = trig_ff[s-1];
      end
   end

   always_comb begin
      mx_in = MW'(quo_ff[QW]) * MW'(trig_ff[QW].smag);
      my_in = MW'(quo_ff[QW]) * MW'(trig_ff[QW].cmag);

      rx = ({1'b0, mx_ff} + ((MW + 1)'(1) << (7 + TRIG_FRAC_BITS))) >> (8 + TRIG_FRAC_BITS);
      ry = ({1'b0, my_ff} + ((MW + 1)'(1) << (7 + TRIG_FRAC_BITS))) >> (8 + TRIG_FRAC_BITS);
      dx = nx_ff ? -XW'(rx) : XW'(rx);
      dy = ny_ff ? -XW'(ry) : XW'(ry);

      px_in = XW'(cfg.center_x) + dx;
      py_in = XW'(cfg.center_y) - dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= OUTS; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= q_valid;
         for (int i = 1; i <= OUTS; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= QW; i++) begin
            rem_ff[i]  <= rem_in[i];
            quo_ff[i]  <= quo_in[i];
            nlo_ff[i]  <= nlo_in[i];
            trig_ff[i] <= trig_in[i];
         end
         mx_ff <= mx_in;
         my_ff <= my_in;
         nx_ff <= trig_ff[QW].sneg;
         ny_ff <= trig_ff[QW].cneg;
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   assign rsp_tvalid = v_ff[OUTS];
   assign rsp_tdata  = {py_ff, px_ff};

   a_trig_index: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_sin.idx <= 7'd90) && (q_cos.idx <= 7'd90))
      else $error("trig index outside quarter table");

   a_mul_advance: assert property (@(posedge clock) disable iff (reset)
      (en && v_ff[QW]) |=> v_ff[MUL])
      else $error("divider result lost before multiply stage");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(v_ff[MUL]))
      else $error("output word without multiply stage word");

endmodule

// ===== rtl/polar_to_plot_point.sv =====
// Top level of the polar to plot point block: front end, queue and back end.
// Path: an accepted req word waits in the queue, then passes the divider stages, the multiply
// register and the output register to rsp_tvalid. Throughput: one word per cycle while
// rsp_tready is high; the radius divider is pipelined one quotient bit per stage.
// Reset: synchronous; range 30 nm, center (128, 128), queue and pipeline emptied.
module polar_to_plot_point #(
   parameter int PLOT_RADIUS    = ptp_pkg::PLOT_RADIUS_DEF,
   parameter int TRIG_FRAC_BITS = ptp_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ptp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ptp_pkg::REQ_DATA_W-1:0] req_tdata,   // distance_tenths[14:0], bearing[23:15]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ptp_pkg::RSP_DATA_W-1:0] rsp_tdata    // pixel_x[11:0], pixel_y[23:12]
);

   localparam int NUM_W  = ptp_pkg::num_width(PLOT_RADIUS);
   localparam int WORD_W = NUM_W + 2 * $bits(ptp_pkg::trig_ref_type);

   logic              q_full;
   logic              q_push;
   logic [WORD_W-1:0] q_wdata;
   logic              q_empty;
   logic              q_pop;
   logic [WORD_W-1:0] q_rdata;
   ptp_pkg::cfg_type  cfg;

   ptp_front #(
      .PLOT_RADIUS (PLOT_RADIUS),
      .NUM_W       (NUM_W),
      .WORD_W      (WORD_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wdata),
      .cfg        (cfg)
   );

   ptp_queue #(
      .WIDTH (WORD_W),
      .DEPTH (ptp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   ptp_back #(
      .PLOT_RADIUS    (PLOT_RADIUS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
      .NUM_W          (NUM_W),
      .WORD_W         (WORD_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (!q_empty),
      .q_pop      (q_pop),
      .q_data     (q_rdata),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
